// ===== rtl/nsp_pkg.sv =====
`default_nettype none

package nsp_pkg;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FILE_FORMAT  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUCLEIC_KIND = 1'd1;

  // file formats
  localparam logic [1:0] FMT_RAW   = 2'd0;
  localparam logic [1:0] FMT_FASTA = 2'd1;
  localparam logic [1:0] FMT_FASTQ = 2'd2;

  // input operations
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PACKED = 2'd0;
  localparam logic [1:0] KIND_LETTER = 2'd1;
  localparam logic [1:0] KIND_COUNT  = 2'd2;

  // characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_U       = 8'h55;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0] file_format;
    logic       nucleic_kind;
  } cfg_t;

  // results caused by one word: a packed byte or a flush run
  typedef struct packed {
    logic       is_flush;
    logic       rna;
    logic [1:0] cnt;
    logic [5:0] codes;
    logic [7:0] packed_byte;
  } grp_t;

endpackage

`default_nettype wire

// ===== rtl/nsp_parser.sv =====
`default_nettype none

module nsp_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire nsp_pkg::in_t  item,
  input  wire nsp_pkg::cfg_t cfg,
  output nsp_pkg::grp_t      grp,
  output logic               grp_vld
);

  logic       at_line_start_r, at_line_start_nxt;
  logic       skipping_line_r, skipping_line_nxt;
  logic       skip_next_line_r, skip_next_line_nxt;
  logic [5:0] pending_codes_r, pending_codes_nxt;
  logic [1:0] pending_count_r, pending_count_nxt;

  logic [7:0] up_b;
  logic       code_ok;
  logic [1:0] code;

  // upper-case and letter decode
  always_comb begin
    up_b = item.byte_value;
    if (item.byte_value >= nsp_pkg::CH_LOW_A && item.byte_value <= nsp_pkg::CH_LOW_Z) begin
      up_b = item.byte_value - nsp_pkg::CASE_DIFF;
    end
    code_ok = 1'b1;
    code    = 2'd0;
    if (up_b == nsp_pkg::CH_A) begin
      code = 2'd0;
    end else if (up_b == nsp_pkg::CH_C) begin
      code = 2'd1;
    end else if (up_b == nsp_pkg::CH_G) begin
      code = 2'd2;
    end else if (up_b == nsp_pkg::CH_T && !cfg.nucleic_kind) begin
      code = 2'd3;
    end else if (up_b == nsp_pkg::CH_U && cfg.nucleic_kind) begin
      code = 2'd3;
    end else begin
      code_ok = 1'b0;
    end
  end

  always_comb begin
    at_line_start_nxt  = at_line_start_r;
    skipping_line_nxt  = skipping_line_r;
    skip_next_line_nxt = skip_next_line_r;
    pending_codes_nxt  = pending_codes_r;
    pending_count_nxt  = pending_count_r;
    grp_vld            = 1'b0;
    grp.is_flush       = 1'b0;
    grp.rna            = cfg.nucleic_kind;
    grp.cnt            = pending_count_r;
    grp.codes          = pending_codes_r;
    grp.packed_byte    = {pending_codes_r, code};

    if (item.operation == nsp_pkg::OP_FLUSH) begin
      grp_vld            = 1'b1;
      grp.is_flush       = 1'b1;
      at_line_start_nxt  = 1'b1;
      skipping_line_nxt  = 1'b0;
      skip_next_line_nxt = 1'b0;
      pending_codes_nxt  = 6'd0;
      pending_count_nxt  = 2'd0;
    end else if (item.byte_value == nsp_pkg::CH_NEWLINE) begin
      // empty line uses up a pending skip
      if (at_line_start_r) begin
        skip_next_line_nxt = 1'b0;
      end
      at_line_start_nxt = 1'b1;
      skipping_line_nxt = 1'b0;
    end else begin
      if (at_line_start_r) begin
        at_line_start_nxt = 1'b0;
        skipping_line_nxt = 1'b0;
        if (skip_next_line_r) begin
          skip_next_line_nxt = 1'b0;
          skipping_line_nxt  = 1'b1;
        end else if (cfg.file_format == nsp_pkg::FMT_FASTQ &&
                     item.byte_value == nsp_pkg::CH_AT) begin
          skipping_line_nxt = 1'b1;
        end else if (cfg.file_format == nsp_pkg::FMT_FASTQ &&
                     item.byte_value == nsp_pkg::CH_PLUS) begin
          skipping_line_nxt  = 1'b1;
          skip_next_line_nxt = 1'b1;
        end else if (cfg.file_format == nsp_pkg::FMT_FASTA &&
                     item.byte_value == nsp_pkg::CH_GT) begin
          skipping_line_nxt = 1'b1;
        end
      end
      if (!skipping_line_nxt && code_ok) begin
        if (pending_count_r == 2'd3) begin
          grp_vld           = 1'b1;
          pending_codes_nxt = 6'd0;
          pending_count_nxt = 2'd0;
        end else begin
          pending_codes_nxt = {pending_codes_r[3:0], code};
          pending_count_nxt = pending_count_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r  <= 1'b1;
      skipping_line_r  <= 1'b0;
      skip_next_line_r <= 1'b0;
      pending_codes_r  <= 6'd0;
      pending_count_r  <= 2'd0;
    end else if (fire) begin
      at_line_start_r  <= at_line_start_nxt;
      skipping_line_r  <= skipping_line_nxt;
      skip_next_line_r <= skip_next_line_nxt;
      pending_codes_r  <= pending_codes_nxt;
      pending_count_r  <= pending_count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nsp_out_seq.sv =====
`default_nettype none

module nsp_out_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire nsp_pkg::grp_t grp_in,
  output logic               busy,
  output logic               done,
  output logic               out_valid,
  input  wire logic          out_stall,
  output nsp_pkg::out_t      out_data
);

  logic          busy_r;
  logic [1:0]    idx_r;
  nsp_pkg::grp_t grp_r;
  logic [1:0]    sh;
  logic [1:0]    c;

  assign busy      = busy_r;
  assign out_valid = busy_r;
  assign done      = busy_r && !out_stall && out_data.last;

  // position of the letter being sent, counted from the newest code
  assign sh = grp_r.cnt - idx_r - 2'd1;

  always_comb begin
    unique case (sh)
      2'd0:    c = grp_r.codes[1:0];
      2'd1:    c = grp_r.codes[3:2];
      default: c = grp_r.codes[5:4];
    endcase
  end

  always_comb begin
    out_data.out_byte = grp_r.packed_byte;
    out_data.out_kind = nsp_pkg::KIND_PACKED;
    out_data.last     = 1'b1;
    if (grp_r.is_flush) begin
      if (idx_r == grp_r.cnt) begin
        out_data.out_byte = {6'd0, grp_r.cnt};
        out_data.out_kind = nsp_pkg::KIND_COUNT;
      end else begin
        out_data.out_kind = nsp_pkg::KIND_LETTER;
        out_data.last     = 1'b0;
        unique case (c)
          2'd0:    out_data.out_byte = nsp_pkg::CH_A;
          2'd1:    out_data.out_byte = nsp_pkg::CH_C;
          2'd2:    out_data.out_byte = nsp_pkg::CH_G;
          default: out_data.out_byte = grp_r.rna ? nsp_pkg::CH_U : nsp_pkg::CH_T;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r && !out_stall) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nucleotide_stream_2bit_packer.sv =====
`default_nettype none

// channel | direction | handshake         | payload
// in_     | input     | in_valid/in_stall | nsp_pkg::in_t  (operation, byte_value)
// out_    | output    | out_valid/out_stall | nsp_pkg::out_t (out_byte, out_kind, last)
// cfg_    | input     | cfg_we            | cfg_index, cfg_data
//
// one input word per cycle while in_stall is low; a data word gives at most one result in the next cycle
// a flush word gives n+1 results (n = 0..3 leftover letters), one per cycle while out_stall is low
// the result sequencer holds one word's results; input stalls until its last one leaves
// synchronous active-low reset: format fasta, dna, at line start, nothing pending
// out_stall holds the current result and stalls input the same cycle

module nucleotide_stream_2bit_packer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire nsp_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output nsp_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [nsp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [nsp_pkg::CfgDataW-1:0]  cfg_data
);

  logic [1:0]    file_format_r;
  logic          nucleic_kind_r;
  nsp_pkg::cfg_t cfg;
  nsp_pkg::grp_t grp;
  logic          grp_vld;
  logic          fire;
  logic          seq_busy;
  logic          seq_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_format_r  <= nsp_pkg::FMT_FASTA;
      nucleic_kind_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsp_pkg::CFG_FILE_FORMAT:  file_format_r  <= cfg_data[1:0];
        nsp_pkg::CFG_NUCLEIC_KIND: nucleic_kind_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.file_format  = file_format_r;
  assign cfg.nucleic_kind = nucleic_kind_r;

  // take a new word when the sequencer is free or sends its final result now
  assign in_stall = seq_busy && !seq_done;
  assign fire     = in_valid && !in_stall;

  // line tracking, filtering and packing
  nsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (in_data),
    .cfg     (cfg),
    .grp     (grp),
    .grp_vld (grp_vld)
  );

  // result register and flush sequencing
  nsp_out_seq u_out_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && grp_vld),
    .grp_in    (grp),
    .busy      (seq_busy),
    .done      (seq_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a stalled result keeps the input stalled
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while a result is stalled");

  // a flush run continues until its count result
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid &&
      (out_data.out_kind == nsp_pkg::KIND_LETTER || out_data.out_kind == nsp_pkg::KIND_COUNT))
    else $error("flush run broken");

  // count result is small and ends the run
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == nsp_pkg::KIND_COUNT |->
      out_data.last && out_data.out_byte[7:2] == 6'd0)
    else $error("bad count result");

  // letters never end a run
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == nsp_pkg::KIND_LETTER |-> !out_data.last)
    else $error("letter marked last");

endmodule

`default_nettype wire
